>>> hdl/cfsd_pkg.sv
`timescale 1ns / 1ps

package cfsd_pkg;

   // Queue between front and back
   localparam int FifoDepth = 4;
   localparam int FifoPtrW  = $clog2(FifoDepth);

   // Received identifiers
   localparam logic [28:0] ID_SOC       = 29'h355;
   localparam logic [28:0] ID_PACK      = 29'h356;
   localparam logic [28:0] ID_BMS       = 29'h373;
   localparam logic [28:0] ID_RPM       = 29'h1DA;
   localparam logic [28:0] ID_MOTOR     = 29'h55A;
   localparam logic [28:0] ID_SHUNT_I   = 29'h521;
   localparam logic [28:0] ID_SHUNT_U   = 29'h522;
   localparam logic [28:0] ID_SHUNT_KW  = 29'h526;
   localparam logic [28:0] ID_SHUNT_AH  = 29'h527;
   localparam logic [28:0] ID_SHUNT_KWH = 29'h528;
   localparam logic [28:0] ID_LV        = 29'h39F;
   localparam logic [28:0] ID_PLUG      = 29'h323;
   localparam logic [28:0] ID_CHARGER   = 29'h33B;

   localparam logic [28:0] OWN_ID_RESET = 29'h7FF;

   // Signal codes on the result channel
   localparam logic [4:0] SIG_NONE         = 5'd0;
   localparam logic [4:0] SIG_SOC          = 5'd1;
   localparam logic [4:0] SIG_PACK_VOLT    = 5'd2;
   localparam logic [4:0] SIG_TEMP_MAX     = 5'd3;
   localparam logic [4:0] SIG_CELL_VMIN    = 5'd4;
   localparam logic [4:0] SIG_CELL_VMAX    = 5'd5;
   localparam logic [4:0] SIG_TEMP_MIN     = 5'd6;
   localparam logic [4:0] SIG_RPM          = 5'd7;
   localparam logic [4:0] SIG_MOTOR_TEMP   = 5'd8;
   localparam logic [4:0] SIG_INV_TEMP     = 5'd9;
   localparam logic [4:0] SIG_SHUNT_I      = 5'd10;
   localparam logic [4:0] SIG_SHUNT_U      = 5'd11;
   localparam logic [4:0] SIG_SHUNT_KW     = 5'd12;
   localparam logic [4:0] SIG_SHUNT_AH     = 5'd13;
   localparam logic [4:0] SIG_SHUNT_KWH    = 5'd14;
   localparam logic [4:0] SIG_LV_MV        = 5'd15;
   localparam logic [4:0] SIG_LV_AMPS      = 5'd16;
   localparam logic [4:0] SIG_PLUG         = 5'd17;
   localparam logic [4:0] SIG_CHARGER_TEMP = 5'd18;
   localparam logic [4:0] SIG_COLLISION    = 5'd19;

   // Frame class decided by the front
   typedef enum logic [3:0] {
      KIND_NONE,
      KIND_SOC,
      KIND_PACK,
      KIND_BMS,
      KIND_RPM,
      KIND_MOTOR,
      KIND_SHUNT_I,
      KIND_SHUNT_U,
      KIND_SHUNT_KW,
      KIND_SHUNT_AH,
      KIND_SHUNT_KWH,
      KIND_LV,
      KIND_PLUG,
      KIND_CHARGER,
      KIND_COLLISION
   } kind_type;

   typedef struct packed {
      logic [28:0] frame_id;
      logic [3:0]  frame_len;
      logic [63:0] payload;
   } req_type;

   typedef struct packed {
      logic [4:0]         signal_code;
      logic signed [31:0] signal_value;
      logic [31:0]        frame_number;
      logic               last_of_frame;
   } rsp_type;

   // One classified frame waiting for the back
   typedef struct packed {
      kind_type    kind;
      logic [1:0]  last_idx;
      logic [63:0] bytes;
      logic [31:0] frame_number;
   } entry_type;

endpackage

>>> hdl/cfsd_front.sv
`timescale 1ns / 1ps

module cfsd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cfsd_pkg::req_type  req_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [28:0]        csr_data,
   input  logic               fifo_full,
   output logic               push,
   output cfsd_pkg::entry_type entry
);
   import cfsd_pkg::*;

   logic [28:0] own_id_ff, own_id_in;
   logic [31:0] count_ff, count_in;
   logic [3:0]  len_c;
   logic [63:0] bytes_c;
   kind_type    kind_c;
   logic [1:0]  last_c;

   assign csr_ready = 1'b1;
   assign req_stall = fifo_full;
   assign push      = req_valid && !fifo_full;

   // Register write and frame counter
   always_comb begin
      own_id_in = csr_valid ? csr_data : own_id_ff;
      count_in  = push ? count_ff + 32'd1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= OWN_ID_RESET;
         count_ff  <= '0;
      end else begin
         own_id_ff <= own_id_in;
         count_ff  <= count_in;
      end
   end

   // Clamp length and zero bytes past it
   always_comb begin
      len_c = (req_data.frame_len > 4'd8) ? 4'd8 : req_data.frame_len;
      for (int i = 0; i < 8; i++) begin
         bytes_c[8*i +: 8] = (4'(i) < len_c) ? req_data.payload[8*i +: 8] : 8'h00;
      end
   end

   // Classify identifier; known IDs take priority over the own ID
   always_comb begin
      kind_c = KIND_NONE;
      last_c = 2'd0;
      case (req_data.frame_id)
         ID_SOC: begin
            if (len_c >= 4'd1) kind_c = KIND_SOC;
         end
         ID_PACK: begin
            if (len_c >= 4'd6) begin
               kind_c = KIND_PACK;
               last_c = 2'd1;
            end
         end
         ID_BMS: begin
            if (len_c >= 4'd8) begin
               kind_c = KIND_BMS;
               last_c = 2'd3;
            end
         end
         ID_RPM: begin
            if (len_c >= 4'd6) kind_c = KIND_RPM;
         end
         ID_MOTOR: begin
            if (len_c >= 4'd3) begin
               kind_c = KIND_MOTOR;
               last_c = 2'd1;
            end
         end
         ID_SHUNT_I:   kind_c = KIND_SHUNT_I;
         ID_SHUNT_U:   kind_c = KIND_SHUNT_U;
         ID_SHUNT_KW:  kind_c = KIND_SHUNT_KW;
         ID_SHUNT_AH:  kind_c = KIND_SHUNT_AH;
         ID_SHUNT_KWH: kind_c = KIND_SHUNT_KWH;
         ID_LV: begin
            if (len_c >= 4'd5) begin
               kind_c = KIND_LV;
               last_c = 2'd1;
            end
         end
         ID_PLUG: begin
            if (len_c >= 4'd6) kind_c = KIND_PLUG;
         end
         ID_CHARGER: begin
            if (len_c >= 4'd4) kind_c = KIND_CHARGER;
         end
         default: begin
            if (req_data.frame_id == own_id_ff) kind_c = KIND_COLLISION;
         end
      endcase
   end

   assign entry.kind         = kind_c;
   assign entry.last_idx     = last_c;
   assign entry.bytes        = bytes_c;
   assign entry.frame_number = count_ff + 32'd1;

endmodule

>>> hdl/cfsd_fifo.sv
`timescale 1ns / 1ps

module cfsd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cfsd_pkg::entry_type push_data,
   input  logic                pop,
   output cfsd_pkg::entry_type head,
   output logic                empty,
   output logic                full
);
   import cfsd_pkg::*;

   entry_type           mem_ff [FifoDepth];
   logic [FifoPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FifoPtrW:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (FifoPtrW+1)'(FifoDepth));
   assign head  = mem_ff[rd_ptr_ff];

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> hdl/cfsd_back.sv
`timescale 1ns / 1ps

module cfsd_back (
   input  logic                clock,
   input  logic                reset,
   input  cfsd_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cfsd_pkg::rsp_type   rsp_data
);
   import cfsd_pkg::*;

   // (f - 32) * 50 / 9, truncating; /9 done as * 7282 / 65536 folded with * 50
   function automatic logic [31:0] fahr_tenths(input logic [7:0] f);
      logic [9:0]  d;
      logic        neg;
      logic [7:0]  mag;
      logic [26:0] prod;
      logic [31:0] q;
      d    = {2'b00, f} - 10'd32;
      neg  = d[9];
      mag  = neg ? 8'(-d) : d[7:0];
      prod = {19'b0, mag} * 27'd364100;
      q    = {21'b0, prod[26:16]};
      return neg ? -q : q;
   endfunction

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   rsp_type     data_ff, data_in;
   logic        out_free;
   logic        load;
   logic [7:0]  b [8];
   logic [4:0]  code_c;
   logic [31:0] value_c;
   logic [15:0] bms_sel;
   logic [15:0] bms_diff;
   logic [15:0] bms_temp;
   logic [14:0] rpm_raw;
   logic [14:0] lv_mv;
   logic [8:0]  chg_diff;

   assign out_free  = !valid_ff || !rsp_stall;
   assign load      = !empty && out_free;
   assign pop       = load && (idx_ff == head.last_idx);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) b[i] = head.bytes[8*i +: 8];
   end

   // Shared operands
   always_comb begin
      bms_sel  = idx_ff[0] ? {b[7], b[6]} : {b[5], b[4]};
      bms_diff = bms_sel - 16'd273;
      bms_temp = 16'(bms_diff * 16'd10);
      rpm_raw  = {b[4], b[5][7:1]};
      lv_mv    = 15'({7'b0, b[1]} * 15'd125);
      chg_diff = {1'b0, b[3]} - 9'd50;
   end

   // Decode one signal of the head frame
   always_comb begin
      code_c  = SIG_NONE;
      value_c = '0;
      case (head.kind)
         KIND_SOC: begin
            code_c  = SIG_SOC;
            value_c = {24'b0, b[0]};
         end
         KIND_PACK: begin
            if (idx_ff == 2'd0) begin
               code_c  = SIG_PACK_VOLT;
               value_c = {16'b0, b[1], b[0]};
            end else begin
               code_c  = SIG_TEMP_MAX;
               value_c = {{16{b[5][7]}}, b[5], b[4]};
            end
         end
         KIND_BMS: begin
            case (idx_ff)
               2'd0: begin
                  code_c  = SIG_CELL_VMIN;
                  value_c = {16'b0, b[1], b[0]};
               end
               2'd1: begin
                  code_c  = SIG_CELL_VMAX;
                  value_c = {16'b0, b[3], b[2]};
               end
               2'd2: begin
                  code_c  = SIG_TEMP_MIN;
                  value_c = {{16{bms_temp[15]}}, bms_temp};
               end
               default: begin
                  code_c  = SIG_TEMP_MAX;
                  value_c = {{16{bms_temp[15]}}, bms_temp};
               end
            endcase
         end
         KIND_RPM: begin
            code_c = SIG_RPM;
            if (rpm_raw == 15'h7FFF) value_c = '0;
            else if (rpm_raw > 15'h3FFF) value_c = {17'b0, rpm_raw} - 32'h7FFF;
            else value_c = {17'b0, rpm_raw};
         end
         KIND_MOTOR: begin
            if (idx_ff == 2'd0) begin
               code_c  = SIG_MOTOR_TEMP;
               value_c = fahr_tenths(b[1]);
            end else begin
               code_c  = SIG_INV_TEMP;
               value_c = fahr_tenths(b[2]);
            end
         end
         KIND_SHUNT_I: begin
            code_c  = SIG_SHUNT_I;
            value_c = {b[5], b[4], b[3], b[2]};
         end
         KIND_SHUNT_U: begin
            code_c  = SIG_SHUNT_U;
            value_c = {b[5], b[4], b[3], b[2]};
         end
         KIND_SHUNT_KW: begin
            code_c  = SIG_SHUNT_KW;
            value_c = {b[5], b[4], b[3], b[2]};
         end
         KIND_SHUNT_AH: begin
            code_c  = SIG_SHUNT_AH;
            value_c = {b[5], b[4], b[3], b[2]};
         end
         KIND_SHUNT_KWH: begin
            code_c  = SIG_SHUNT_KWH;
            value_c = {b[5], b[4], b[3], b[2]};
         end
         KIND_LV: begin
            if (idx_ff == 2'd0) begin
               code_c  = SIG_LV_MV;
               value_c = {17'b0, lv_mv};
            end else begin
               code_c  = SIG_LV_AMPS;
               value_c = {24'b0, b[4]};
            end
         end
         KIND_PLUG: begin
            code_c  = SIG_PLUG;
            value_c = (b[5] == 8'd1) ? 32'd1 : 32'd0;
         end
         KIND_CHARGER: begin
            code_c  = SIG_CHARGER_TEMP;
            value_c = {{23{chg_diff[8]}}, chg_diff} * 32'd10;
         end
         KIND_COLLISION: begin
            code_c  = SIG_COLLISION;
            value_c = '0;
         end
         default: begin
            code_c  = SIG_NONE;
            value_c = '0;
         end
      endcase
   end

   // Output register and per-frame signal index
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in              = 1'b1;
         data_in.signal_code   = code_c;
         data_in.signal_value  = $signed(value_c);
         data_in.frame_number  = head.frame_number;
         data_in.last_of_frame = pop;
         idx_in                = pop ? 2'd0 : idx_ff + 2'd1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

>>> hdl/can_frame_signal_decoder.sv
`timescale 1ns / 1ps

// CAN frame signal decoder.
// req_*: one received frame per word (id, length code, eight payload bytes),
//   taken when req_valid is high and req_stall low. req_stall rises only
//   while the four-entry frame queue is full.
// rsp_*: decoded signal words, one to four per frame in order, with the
//   running frame number; last_of_frame marks the final word of a frame.
//   A word is taken when rsp_valid is high and rsp_stall low; a stalled word
//   holds in the output register while new frames keep filling the queue.
// csr_*: write of the own transmit id, always ready.
// Path: an accepted frame is written into the queue; its words are decoded from
//   the queue head into the output register, from which they are taken.
// Throughput: one word per cycle out of the decode stage while the queue holds a
//   frame and the output word is not stalled; a frame gives one word per signal.
// Reset clears the counter, the queue, the output valid flag and the signal index,
// and loads the own id with 0x7FF.
module can_frame_signal_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cfsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfsd_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [28:0]       csr_data
);
   import cfsd_pkg::*;

   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      pop;
   logic      empty;
   logic      full;

   cfsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .fifo_full (full),
      .push      (push),
      .entry     (push_entry)
   );

   cfsd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   cfsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // None, collision and SOC words, each alone in its frame, always end it
   a_single_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.signal_code == SIG_NONE ||
                    rsp_data.signal_code == SIG_COLLISION ||
                    rsp_data.signal_code == SIG_SOC) |-> rsp_data.last_of_frame)
      else $error("single-signal word without last_of_frame");

   // A none word carries zero
   a_none_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.signal_code == SIG_NONE |-> rsp_data.signal_value == 0)
      else $error("none word with nonzero value");

   // Words of one frame follow without a gap
   a_frame_burst : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_of_frame |=>
         rsp_valid && rsp_data.frame_number == $past(rsp_data.frame_number))
      else $error("gap or frame change inside a frame");

   // Queue never pops while empty
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
   import cfsd_pkg::*;

   localparam int CycleLimit = 400000;
   localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

   // A frame waiting to be sent; the flag holds it back until all words are in
   typedef struct packed {
      logic    hold_for_drain;
      req_type frame;
   } pending_frame_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [28:0] csr_data = '0;

   pending_frame_type pending_frames [$];
   rsp_type           expected_words [$];
   pending_frame_type next_item;

   // Predictor state
   logic [28:0] own_id = OWN_ID_RESET;
   logic [31:0] frame_count = '0;

   int error_count = 0;
   int cycle_count = 0;
   int src_wait = 0;
   int sink_wait = 0;
   bit src_quiet = 1'b0;
   bit sink_quiet = 1'b0;

   can_frame_signal_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Kelvin word to tenths of a degree Celsius, wrapped to 16 bits
   function automatic logic [31:0] kelvin_tenths(input logic [15:0] raw);
      logic [31:0] wide;
      wide = ({16'h0, raw} - 32'd273) * 32'd10;
      return {{16{wide[15]}}, wide[15:0]};
   endfunction

   // Fahrenheit byte to tenths of a degree Celsius, truncating toward zero
   function automatic logic [31:0] fahr_tenths(input logic [7:0] f);
      int c;
      c = (int'(f) - 32) * 50 / 9;
      return c;
   endfunction

   function automatic int pick_wait(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 13);
   endfunction

   // Decode one accepted frame into the words it should produce
   function automatic void decode_frame(input req_type f);
      logic [7:0]  b [8];
      logic [4:0]  codes [4];
      logic [31:0] vals [4];
      logic [14:0] r;
      int          n;
      int          len;
      int          rpm;
      rsp_type     w;
      n = 0;
      len = (f.frame_len > 4'd8) ? 8 : int'(f.frame_len);
      for (int i = 0; i < 8; i++) begin
         b[i] = (i < len) ? f.payload[8*i +: 8] : 8'h00;
      end
      frame_count = frame_count + 32'd1;

      case (f.frame_id)
         ID_SOC: if (len >= 1) begin
            codes[0] = SIG_SOC;
            vals[0] = {24'h0, b[0]};
            n = 1;
         end
         ID_PACK: if (len >= 6) begin
            codes[0] = SIG_PACK_VOLT;
            vals[0] = {16'h0, b[1], b[0]};
            codes[1] = SIG_TEMP_MAX;
            vals[1] = {{16{b[5][7]}}, b[5], b[4]};
            n = 2;
         end
         ID_BMS: if (len >= 8) begin
            codes[0] = SIG_CELL_VMIN;
            vals[0] = {16'h0, b[1], b[0]};
            codes[1] = SIG_CELL_VMAX;
            vals[1] = {16'h0, b[3], b[2]};
            codes[2] = SIG_TEMP_MIN;
            vals[2] = kelvin_tenths({b[5], b[4]});
            codes[3] = SIG_TEMP_MAX;
            vals[3] = kelvin_tenths({b[7], b[6]});
            n = 4;
         end
         ID_RPM: if (len >= 6) begin
            r = {b[4], b[5][7:1]};
            // all ones means no reading; the upper half folds to negative
            if (r == 15'h7FFF) rpm = 0;
            else if (r > 15'h3FFF) rpm = int'(r) - 32'h7FFF;
            else rpm = int'(r);
            codes[0] = SIG_RPM;
            vals[0] = rpm;
            n = 1;
         end
         ID_MOTOR: if (len >= 3) begin
            codes[0] = SIG_MOTOR_TEMP;
            vals[0] = fahr_tenths(b[1]);
            codes[1] = SIG_INV_TEMP;
            vals[1] = fahr_tenths(b[2]);
            n = 2;
         end
         ID_SHUNT_I, ID_SHUNT_U, ID_SHUNT_KW, ID_SHUNT_AH, ID_SHUNT_KWH: begin
            codes[0] = (f.frame_id == ID_SHUNT_I)  ? SIG_SHUNT_I  :
                       (f.frame_id == ID_SHUNT_U)  ? SIG_SHUNT_U  :
                       (f.frame_id == ID_SHUNT_KW) ? SIG_SHUNT_KW :
                       (f.frame_id == ID_SHUNT_AH) ? SIG_SHUNT_AH : SIG_SHUNT_KWH;
            vals[0] = {b[5], b[4], b[3], b[2]};
            n = 1;
         end
         ID_LV: if (len >= 5) begin
            codes[0] = SIG_LV_MV;
            vals[0] = {24'h0, b[1]} * 32'd125;
            codes[1] = SIG_LV_AMPS;
            vals[1] = {24'h0, b[4]};
            n = 2;
         end
         ID_PLUG: if (len >= 6) begin
            codes[0] = SIG_PLUG;
            vals[0] = (b[5] == 8'd1) ? 32'd1 : 32'd0;
            n = 1;
         end
         ID_CHARGER: if (len >= 4) begin
            codes[0] = SIG_CHARGER_TEMP;
            vals[0] = (int'(b[3]) - 50) * 10;
            n = 1;
         end
         default: if (f.frame_id == own_id) begin
            codes[0] = SIG_COLLISION;
            vals[0] = 32'd0;
            n = 1;
         end
      endcase

      // Unknown or short frames still produce one word
      if (n == 0) begin
         codes[0] = SIG_NONE;
         vals[0] = 32'd0;
         n = 1;
      end

      for (int i = 0; i < n; i++) begin
         w.signal_code = codes[i];
         w.signal_value = vals[i];
         w.frame_number = frame_count;
         w.last_of_frame = (i == n - 1);
         expected_words.push_back(w);
      end
   endfunction

   task automatic report_error(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      $display("ERROR %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   task automatic check_word(input rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         report_error("word with none pending, frame_number", got.frame_number, 0);
      end else begin
         want = expected_words.pop_front();
         if (got.signal_code !== want.signal_code)
            report_error("signal_code", got.signal_code, want.signal_code);
         if (got.signal_value !== want.signal_value)
            report_error("signal_value", got.signal_value, want.signal_value);
         if (got.frame_number !== want.frame_number)
            report_error("frame_number", got.frame_number, want.frame_number);
         if (got.last_of_frame !== want.last_of_frame)
            report_error("last_of_frame", got.last_of_frame, want.last_of_frame);
      end
   endtask

   // Frame driver: predicts on acceptance, then idles or sends the next frame
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         src_wait = 0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_frame(req_data);
            if ($urandom_range(0, 15) == 0) src_quiet = !src_quiet;
            src_wait = pick_wait(src_quiet);
         end
         if (!req_valid || !req_stall) begin
            if (src_wait > 0) begin
               req_valid <= 1'b0;
               src_wait--;
            end else if (pending_frames.size() != 0 &&
                         !(pending_frames[0].hold_for_drain &&
                           expected_words.size() != 0)) begin
               next_item = pending_frames.pop_front();
               req_valid <= 1'b1;
               req_data <= next_item.frame;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Word monitor: checks each accepted word, then stalls for a random stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_word(rsp_data);
            if ($urandom_range(0, 15) == 0) sink_quiet = !sink_quiet;
            sink_wait = pick_wait(sink_quiet);
         end
         if (sink_wait > 0) begin
            rsp_stall <= 1'b1;
            sink_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL can_frame_signal_decoder");
         $finish;
      end
   end

   task automatic queue_frame(input logic [28:0] id, input logic [3:0] len,
                              input logic [63:0] bytes, input bit drain = 1'b0);
      pending_frame_type p;
      p.hold_for_drain = drain;
      p.frame.frame_id = id;
      p.frame.frame_len = len;
      p.frame.payload = bytes;
      pending_frames.push_back(p);
   endtask

   // Mostly known ids at a usable length, some own id, some unknown ids
   task automatic queue_random_frames(input int count);
      logic [28:0] id;
      logic [63:0] bytes;
      logic [3:0]  len;
      int          need;
      for (int i = 0; i < count; i++) begin
         need = 0;
         case ($urandom_range(0, 19))
            0:  begin id = ID_SOC;       need = 1; end
            1:  begin id = ID_PACK;      need = 6; end
            2:  begin id = ID_BMS;       need = 8; end
            3:  begin id = ID_RPM;       need = 6; end
            4:  begin id = ID_MOTOR;     need = 3; end
            5:  id = ID_SHUNT_I;
            6:  id = ID_SHUNT_U;
            7:  id = ID_SHUNT_KW;
            8:  id = ID_SHUNT_AH;
            9:  id = ID_SHUNT_KWH;
            10: begin id = ID_LV;        need = 5; end
            11: begin id = ID_PLUG;      need = 6; end
            12: begin id = ID_CHARGER;   need = 4; end
            13, 14: id = own_id;
            15, 16, 17: id = 29'($urandom_range(0, 2047));
            default: id = 29'($urandom);
         endcase
         len = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(need, 15))
                                           : 4'($urandom_range(0, 15));
         bytes = {$urandom, $urandom};
         // steer a few frames onto the rpm sentinel and the plug flag
         case ($urandom_range(0, 7))
            0: bytes[47:32] = 16'hFFFF;
            1: bytes[47:40] = 8'h01;
            default: ;
         endcase
         queue_frame(id, len, bytes, i == count / 2);
      end
   endtask

   task automatic wait_for_idle();
      do @(posedge clock);
      while (pending_frames.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_own_id(input logic [28:0] value);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      own_id = value;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed frames with the own id at its reset value
      queue_frame(ID_SOC, 4'd1, AllOnes);
      queue_frame(ID_SOC, 4'd0, AllOnes);
      queue_frame(ID_PACK, 4'd15, 64'h0000_8000_0000_FFFF);
      queue_frame(ID_PACK, 4'd5, AllOnes);
      queue_frame(ID_BMS, 4'd8, 64'hFFFF_0000_FFFF_0000);
      queue_frame(ID_BMS, 4'd9, 64'h0111_0111_1234_5678);
      queue_frame(ID_BMS, 4'd7, AllOnes);
      queue_frame(ID_RPM, 4'd6, 64'h0000_FFFF_0000_0000);
      queue_frame(ID_RPM, 4'd6, 64'h0000_0080_0000_0000);
      queue_frame(ID_RPM, 4'd8, 64'h0000_FE7F_0000_0000);
      queue_frame(ID_MOTOR, 4'd3, 64'h0000_0000_00FF_0000);
      queue_frame(ID_MOTOR, 4'd8, 64'h0000_0000_0021_1F00);
      queue_frame(ID_MOTOR, 4'd2, AllOnes);
      queue_frame(ID_SHUNT_I, 4'd0, AllOnes);
      queue_frame(ID_SHUNT_U, 4'd8, 64'h0000_8000_0000_0000);
      queue_frame(ID_SHUNT_KW, 4'd6, AllOnes);
      queue_frame(ID_SHUNT_AH, 4'd4, AllOnes);
      queue_frame(ID_SHUNT_KWH, 4'd15, 64'h0000_7FFF_FFFF_0000);
      queue_frame(ID_LV, 4'd5, AllOnes);
      queue_frame(ID_LV, 4'd4, AllOnes);
      queue_frame(ID_PLUG, 4'd6, 64'h0000_0100_0000_0000);
      queue_frame(ID_PLUG, 4'd5, AllOnes);
      queue_frame(ID_CHARGER, 4'd4, 64'h0);
      queue_frame(ID_CHARGER, 4'd3, AllOnes);
      queue_frame(OWN_ID_RESET, 4'd0, 64'h0);
      queue_frame(29'h1FFF_FFFF, 4'd8, AllOnes);

      // Own id at the low end
      write_own_id(29'h0);
      queue_frame(29'h0, 4'd15, AllOnes);
      queue_random_frames(50);

      // Own id at the high end
      write_own_id(29'h1FFF_FFFF);
      queue_frame(29'h1FFF_FFFF, 4'd0, 64'h0);
      queue_random_frames(50);

      // Own id on a known id: the known decode wins, short frames give none
      write_own_id(ID_PACK);
      queue_frame(ID_PACK, 4'd5, AllOnes);
      queue_frame(ID_PACK, 4'd6, AllOnes);
      queue_random_frames(50);

      // Arbitrary own id
      write_own_id(29'($urandom_range(0, 29'h1FFF_FFFF)));
      queue_random_frames(100);

      wait_for_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS can_frame_signal_decoder");
      end else begin
         $display("FAIL can_frame_signal_decoder");
      end
      $finish;
   end

endmodule
